// ===== rtl/core/ppid_pkg.sv =====
// Package for the positional PID controller: widths, register index codes
// and the saturate / clamp helpers shared by the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppid_pkg;

    // Q16.16 word and derived widths
    localparam int Q_W    = 32;           // data and gain width
    localparam int LIM_W  = Q_W - 1;      // magnitude limit width
    localparam int FRAC_W = 16;           // fraction bits
    localparam int PROD_W = 2 * Q_W - FRAC_W;  // product after dropping fraction
    localparam int PSUM_W = PROD_W + 1;   // sum of two products
    localparam int SUM_W  = PSUM_W + 1;   // full drive sum before clamp

    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_OUTPUT_LIMIT   = 3'd4
    } cfg_reg_t;

    // Saturate a 33-bit difference to the signed 32-bit range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [Q_W:0] v);
        logic signed [Q_W-1:0] r;
        if (v[Q_W] != v[Q_W-1])
            r = v[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

    // Clamp a wide signed sum to [-lim, +lim]; the result always fits Q_W bits
    function automatic logic signed [Q_W-1:0] clamp_lim(input logic signed [SUM_W-1:0] v,
                                                         input logic [LIM_W-1:0] lim);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [Q_W-1:0]   r;
        hi = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
        lo = -hi;
        if (v > hi)
            r = hi[Q_W-1:0];
        else if (v < lo)
            r = lo[Q_W-1:0];
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ppid_in_if.sv =====
// Input channel of the PID controller: setpoint and measurement, valid/ready.
// Depends on ppid_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ppid_in_if;
    import ppid_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] setpoint;
    logic signed [Q_W-1:0] measured;

    modport source (output valid, output setpoint, output measured, input ready);
    modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ppid_out_if.sv =====
// Output channel of the PID controller: clamped drive value, valid/ready.
// Depends on ppid_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ppid_out_if;
    import ppid_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ppid_qmul.sv =====
// Registered Q16.16 multiply: exact 64-bit product, low fraction bits dropped
// (floor). Depends on ppid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppid_qmul (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic signed [ppid_pkg::Q_W-1:0]    a,
    input  wire logic signed [ppid_pkg::Q_W-1:0]    b,
    output logic signed      [ppid_pkg::PROD_W-1:0] q
);
    import ppid_pkg::*;

    logic signed [2*Q_W-1:0]  prod;
    logic signed [PROD_W-1:0] q_reg;

    // full product; arithmetic drop of the fraction rounds toward minus infinity
    assign prod = a * b;

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= prod[2*Q_W-1:FRAC_W];
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ===== rtl/core/positional_pid_with_clamps.sv =====
// Positional PID controller with integral and output clamps, signed Q16.16.
// Depends on ppid_pkg, ppid_in_if, ppid_out_if and ppid_qmul.
//
// Takes one transaction per clock while the result side keeps up and returns
// exactly one drive value per transaction, in order. Behind the input register
// come the error/difference stage, the multiplier stage (three 32x32 multiplies
// in parallel), the integral update stage and the output register. The integral
// accumulator closes its loop in a single add-and-clamp, so throughput is one
// transaction per cycle unless the output stalls. Each stage holds its
// transaction while the next is full, so bubbles collapse and a waiting result
// does not stop new transactions until all five stages are full. Configuration
// writes are to be made with no transaction in flight; indexes beyond
// output_limit are ignored.
`timescale 1ns / 1ps
`default_nettype none

module positional_pid_with_clamps (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    ppid_in_if.sink                                sample,
    ppid_out_if.source                             result,
    input  wire logic                              cfg_write,
    input  wire logic [ppid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ppid_pkg::Q_W-1:0]          cfg_data
);
    import ppid_pkg::*;

    // configuration
    logic signed [Q_W-1:0]   gain_p_reg;
    logic signed [Q_W-1:0]   gain_i_reg;
    logic signed [Q_W-1:0]   gain_d_reg;
    logic        [LIM_W-1:0] integral_limit_reg;
    logic        [LIM_W-1:0] output_limit_reg;

    // pipeline valids and load enables
    logic [4:0] valid_reg;
    logic [4:0] take;

    // stage 0: input register
    logic signed [Q_W-1:0] setpoint_reg;
    logic signed [Q_W-1:0] measured_reg;
    // stage 1: error and derivative difference
    logic signed [Q_W-1:0] error_next;
    logic signed [Q_W-1:0] diff_next;
    logic signed [Q_W-1:0] error_reg;
    logic signed [Q_W-1:0] diff_reg;
    logic signed [Q_W-1:0] previous_error_reg;
    // stage 2: products
    logic signed [PROD_W-1:0] prod_p;
    logic signed [PROD_W-1:0] prod_i;
    logic signed [PROD_W-1:0] prod_d;
    // stage 3: integral state and P+D sum
    logic signed [Q_W-1:0]    integral_term_reg;
    logic signed [Q_W-1:0]    integral_next;
    logic signed [PSUM_W-1:0] pd_sum_reg;
    // stage 4: output register
    logic signed [Q_W-1:0] drive_reg;
    logic signed [Q_W-1:0] drive_next;

    logic upd_prev;
    logic upd_integral;

    // Load enables: a stage loads when empty or when its content moves on
    assign take[4] = !valid_reg[4] || result.ready;
    assign take[3] = !valid_reg[3] || take[4];
    assign take[2] = !valid_reg[2] || take[3];
    assign take[1] = !valid_reg[1] || take[2];
    assign take[0] = !valid_reg[0] || take[1];

    assign sample.ready = take[0];
    assign result.valid = valid_reg[4];
    assign result.drive = drive_reg;

    assign upd_prev     = valid_reg[0] && take[1];
    assign upd_integral = valid_reg[2] && take[3];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            integral_limit_reg <= '1;
            output_limit_reg   <= '1;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:         gain_p_reg         <= cfg_data;
                REG_GAIN_I:         gain_i_reg         <= cfg_data;
                REG_GAIN_D:         gain_d_reg         <= cfg_data;
                REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[LIM_W-1:0];
                REG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_data[LIM_W-1:0];
                default:            ;
            endcase
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (take[0]) valid_reg[0] <= sample.valid;
            if (take[1]) valid_reg[1] <= valid_reg[0];
            if (take[2]) valid_reg[2] <= valid_reg[1];
            if (take[3]) valid_reg[3] <= valid_reg[2];
            if (take[4]) valid_reg[4] <= valid_reg[3];
        end
    end

    // Stage 0: capture the transaction
    always_ff @(posedge clk)
    begin
        if (take[0])
        begin
            setpoint_reg <= sample.setpoint;
            measured_reg <= sample.measured;
        end
    end

    // Stage 1: saturated error and difference from the previous error
    always_comb
    begin
        error_next = sat_q({setpoint_reg[Q_W-1], setpoint_reg}
                           - {measured_reg[Q_W-1], measured_reg});
        diff_next  = sat_q({error_next[Q_W-1], error_next}
                           - {previous_error_reg[Q_W-1], previous_error_reg});
    end

    always_ff @(posedge clk)
    begin
        if (take[1])
        begin
            error_reg <= error_next;
            diff_reg  <= diff_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            previous_error_reg <= '0;
        else if (upd_prev)
            previous_error_reg <= error_next;
    end

    // Stage 2: the three gain products
    ppid_qmul u_mul_p (.clk(clk), .en(take[2]), .a(gain_p_reg), .b(error_reg), .q(prod_p));
    ppid_qmul u_mul_i (.clk(clk), .en(take[2]), .a(gain_i_reg), .b(error_reg), .q(prod_i));
    ppid_qmul u_mul_d (.clk(clk), .en(take[2]), .a(gain_d_reg), .b(diff_reg),  .q(prod_d));

    // Stage 3: integral accumulate and clamp; P and D summed alongside
    always_comb
    begin
        integral_next = clamp_lim({{(SUM_W-Q_W){integral_term_reg[Q_W-1]}}, integral_term_reg}
                                  + {{(SUM_W-PROD_W){prod_i[PROD_W-1]}}, prod_i},
                                  integral_limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integral_term_reg <= '0;
        else if (upd_integral)
            integral_term_reg <= integral_next;
    end

    always_ff @(posedge clk)
    begin
        if (take[3])
            pd_sum_reg <= {prod_p[PROD_W-1], prod_p} + {prod_d[PROD_W-1], prod_d};
    end

    // Stage 4: full sum, output clamp
    always_comb
    begin
        drive_next = clamp_lim({{(SUM_W-PSUM_W){pd_sum_reg[PSUM_W-1]}}, pd_sum_reg}
                               + {{(SUM_W-Q_W){integral_term_reg[Q_W-1]}}, integral_term_reg},
                               output_limit_reg);
    end

    always_ff @(posedge clk)
    begin
        if (take[4])
            drive_reg <= drive_next;
    end

    // Checks
    logic signed [Q_W:0] ilim_ext;
    logic signed [Q_W:0] olim_ext;
    logic signed [Q_W:0] integ_ext;
    logic signed [Q_W:0] drive_ext;

    assign ilim_ext  = $signed({2'b00, integral_limit_reg});
    assign olim_ext  = $signed({2'b00, output_limit_reg});
    assign integ_ext = $signed({integral_term_reg[Q_W-1], integral_term_reg});
    assign drive_ext = $signed({drive_reg[Q_W-1], drive_reg});

    a_integral_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        upd_integral |=> (integ_ext <= ilim_ext) && (integ_ext >= -ilim_ext))
        else $error("integral term outside its limit after update");

    a_drive_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[3] && take[4]) |=> (drive_ext <= olim_ext) && (drive_ext >= -olim_ext))
        else $error("drive outside output limit");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (valid_reg == '1) && !result.ready)
        else $error("input stalled with room in the pipeline");

    a_prev_error_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        upd_prev |=> previous_error_reg == error_reg)
        else $error("previous error not taken from the stage 1 error");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for positional_pid_with_clamps: directed and random
// setpoint/measurement streams checked against a Q16.16 PID predictor.
// Depends on ppid_pkg, ppid_in_if, ppid_out_if and the controller RTL.
`timescale 1ns / 1ps

module testbench;
    import ppid_pkg::*;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [Q_W-1:0] Q_ONE = 32'sd65536;
    localparam int SETTLE_CYCLES  = 8;     // pipeline depth plus margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction and no write
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_SAMPLES  = 127;

    // One queued action: a register write or a sample transaction
    typedef struct {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  index;
        logic [Q_W-1:0]        data;
        logic signed [Q_W-1:0] setpoint;
        logic signed [Q_W-1:0] measured;
    } stim_t;

    typedef struct {
        logic signed [Q_W-1:0] drive;
        logic signed [Q_W-1:0] setpoint;
        logic signed [Q_W-1:0] measured;
    } drive_exp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [Q_W-1:0]       cfg_data;

    ppid_in_if  sample_ch ();
    ppid_out_if result_ch ();

    positional_pid_with_clamps dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    stim_t      stimulus[$];
    drive_exp_t drive_expect[$];
    int unsigned mismatches = 0;

    // Controller mirror: registers and loop state
    logic signed [Q_W-1:0] kp = '0;
    logic signed [Q_W-1:0] ki = '0;
    logic signed [Q_W-1:0] kd = '0;
    logic [LIM_W-1:0]      int_lim = '1;
    logic [LIM_W-1:0]      out_lim = '1;
    logic signed [Q_W-1:0] last_err = '0;
    logic signed [Q_W-1:0] integ = '0;

    function automatic longint sat_word(input longint v);
        if (v > longint'(Q_MAX))
            return longint'(Q_MAX);
        if (v < longint'(Q_MIN))
            return longint'(Q_MIN);
        return v;
    endfunction

    function automatic longint clamp_mag(input longint v, input logic [LIM_W-1:0] lim);
        longint bound;
        bound = longint'({1'b0, lim});
        if (v > bound)
            return bound;
        if (v < -bound)
            return -bound;
        return v;
    endfunction

    // Q16.16 product, fraction dropped toward minus infinity
    function automatic longint fix_mul(input logic signed [Q_W-1:0] gain, input longint x);
        return (longint'(gain) * x) >>> FRAC_W;
    endfunction

    // One controller step: updates integral and last error, returns the drive
    function automatic logic signed [Q_W-1:0] pid_drive(input logic signed [Q_W-1:0] sp,
                                                         input logic signed [Q_W-1:0] ms);
        longint err;
        longint diff;
        longint acc;
        longint total;
        err   = sat_word(longint'(sp) - longint'(ms));
        diff  = sat_word(err - longint'(last_err));
        acc   = clamp_mag(longint'(integ) + fix_mul(ki, err), int_lim);
        integ = acc[Q_W-1:0];
        total = clamp_mag(fix_mul(kp, err) + acc + fix_mul(kd, diff), out_lim);
        last_err = err[Q_W-1:0];
        return total[Q_W-1:0];
    endfunction

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Idle length: mostly none or short, a few long, with calm stretches
    function automatic int unsigned pick_idle(inout int unsigned calm);
        int unsigned roll;
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            calm = $urandom_range(30, 150);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [Q_W-1:0] rand_word();
        logic signed [Q_W-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0:       v = Q_MAX;
            1:       v = Q_MIN;
            2:       v = {Q_W{v[0]}};
            3, 4, 5: v = v >>> $urandom_range(4, 28);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic signed [Q_W-1:0] rand_gain();
        logic signed [Q_W-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 15))
            0:       v = Q_MAX;
            1:       v = Q_MIN;
            2:       v = '0;
            3:       v = Q_ONE;
            4:       ;
            default: v = v >>> $urandom_range(12, 20);
        endcase
        return v;
    endfunction

    // Top bit is random on purpose: the limit registers ignore it
    function automatic logic [Q_W-1:0] rand_limit();
        logic [Q_W-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            2:       v = {1'b0, {LIM_W{1'b1}}};
            3:       ;
            default: v = {v[Q_W-1], v[LIM_W-1:0] >> $urandom_range(4, 24)};
        endcase
        return v;
    endfunction

    task automatic add_sample(input logic signed [Q_W-1:0] sp, input logic signed [Q_W-1:0] ms);
        stim_t s;
        s = '{1'b0, '0, '0, sp, ms};
        stimulus.push_back(s);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] d);
        stim_t s;
        s = '{1'b1, idx, d, '0, '0};
        stimulus.push_back(s);
    endtask

    // Driver: presents samples, performs register writes once the pipe is empty
    stim_t       cur;
    drive_exp_t  due;
    logic        drv_valid;
    logic        drv_write;
    int unsigned gap_left = 0;
    int unsigned calm_in = 0;
    int unsigned settle = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid    <= 1'b0;
            sample_ch.setpoint <= '0;
            sample_ch.measured <= '0;
            cfg_write          <= 1'b0;
            cfg_index          <= '0;
            cfg_data           <= '0;
        end
        else
        begin
            drv_valid = sample_ch.valid;
            drv_write = 1'b0;
            if (sample_ch.valid && sample_ch.ready)
            begin
                due.setpoint = cur.setpoint;
                due.measured = cur.measured;
                due.drive    = pid_drive(cur.setpoint, cur.measured);
                drive_expect.push_back(due);
                drv_valid = 1'b0;
                gap_left  = pick_idle(calm_in);
            end
            if (drive_expect.size() == 0 && !drv_valid)
                settle++;
            else
                settle = 0;
            if (!drv_valid && stimulus.size() != 0)
            begin
                if (stimulus[0].is_write)
                begin
                    // nothing in flight: safe to change the settings
                    if (settle >= SETTLE_CYCLES)
                    begin
                        cur = stimulus.pop_front();
                        drv_write = 1'b1;
                        case (cur.index)
                            REG_GAIN_P:         kp = cur.data;
                            REG_GAIN_I:         ki = cur.data;
                            REG_GAIN_D:         kd = cur.data;
                            REG_INTEGRAL_LIMIT: int_lim = cur.data[LIM_W-1:0];
                            REG_OUTPUT_LIMIT:   out_lim = cur.data[LIM_W-1:0];
                            default:            ;
                        endcase
                    end
                end
                else if (gap_left != 0)
                    gap_left--;
                else
                begin
                    cur = stimulus.pop_front();
                    drv_valid = 1'b1;
                end
            end
            sample_ch.valid    <= drv_valid;
            sample_ch.setpoint <= cur.setpoint;
            sample_ch.measured <= cur.measured;
            cfg_write          <= drv_write;
            cfg_index          <= cur.index;
            cfg_data           <= cur.data;
        end
    end

    // Monitor: checks each drive result against the oldest expectation
    drive_exp_t  want;
    int unsigned stall_left = 0;
    int unsigned calm_out = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (drive_expect.size() == 0)
                    report($sformatf("drive %0d with no transaction waiting", result_ch.drive));
                else
                begin
                    want = drive_expect.pop_front();
                    if (result_ch.drive !== want.drive)
                        report($sformatf("drive %0d, want %0d (setpoint %0d, measured %0d)",
                                         result_ch.drive, want.drive,
                                         want.setpoint, want.measured));
                end
                stall_left = pick_idle(calm_out);
            end
            else if (stall_left != 0)
                stall_left--;
            result_ch.ready <= (stall_left == 0);
        end
    end

    // Watchdog: no transaction and no write for too long
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (sample_ch.valid && sample_ch.ready)
            || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic signed [Q_W-1:0] target;
        logic signed [Q_W-1:0] plant;
        logic signed [Q_W-1:0] noise;
        longint                p;

        sample_ch.valid    = 1'b0;
        sample_ch.setpoint = '0;
        sample_ch.measured = '0;
        result_ch.ready    = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;

        // Reset settings: zero gains give zero drive even on error overflow
        add_sample(Q_MAX, Q_MIN);
        add_sample(32'sd0, 32'sd0);

        // Unit-ish gains: rounding, error and difference saturation both ways
        add_write(REG_GAIN_P, Q_ONE);
        add_write(REG_GAIN_I, 32'sh0000_4000);
        add_write(REG_GAIN_D, 32'sh0000_8000);
        add_sample(32'sd0, 32'sd0);
        add_sample(32'sd0, 32'sd1);
        add_sample(Q_MAX, Q_MIN);
        add_sample(Q_MIN, Q_MAX);
        add_sample(Q_MAX, Q_MIN);
        add_sample(32'sh0005_0000, 32'sh0002_0000);
        add_sample(-32'sh0003_0000, 32'sh0007_0000);
        add_sample(Q_MIN, 32'sd0);

        // Extreme gains with zero limits: integral and drive pinned at zero
        add_write(REG_GAIN_P, Q_MIN);
        add_write(REG_GAIN_I, Q_MAX);
        add_write(REG_GAIN_D, Q_MAX);
        add_write(REG_INTEGRAL_LIMIT, '0);
        add_write(REG_OUTPUT_LIMIT, '0);
        add_sample(Q_MAX, Q_MIN);
        add_sample(Q_MIN, Q_MAX);
        add_sample(32'sd123456, -32'sd98765);

        // Output clamp at both ends with full limits (top data bit ignored)
        add_write(REG_GAIN_P, Q_MAX);
        add_write(REG_GAIN_D, Q_MIN);
        add_write(REG_INTEGRAL_LIMIT, '1);
        add_write(REG_OUTPUT_LIMIT, '1);
        add_sample(Q_MAX, Q_MIN);
        add_sample(Q_MIN, Q_MAX);

        // Wind the integral up, then drop the gain to zero and the bound below it
        add_write(REG_GAIN_P, '0);
        add_write(REG_GAIN_D, '0);
        add_write(REG_GAIN_I, Q_ONE);
        add_sample(32'sh0064_0000, 32'sd0);
        add_sample(32'sh0064_0000, 32'sd0);
        add_sample(32'sh0064_0000, 32'sd0);
        add_write(REG_GAIN_I, '0);
        add_write(REG_INTEGRAL_LIMIT, 32'h0032_0000);
        add_sample(32'sd0, 32'sd0);

        // Writes beyond the last register must change nothing
        for (int k = int'(REG_OUTPUT_LIMIT) + 1; k < (1 << CFG_IDX_W); k++)
            add_write(CFG_IDX_W'(k), '1);
        add_sample(32'sh0001_0000, 32'sd0);

        // Random phases: mostly a setpoint tracked by a drifting plant
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if ($urandom_range(0, 3) != 0)
                add_write(REG_GAIN_P, rand_gain());
            if ($urandom_range(0, 3) != 0)
                add_write(REG_GAIN_I, rand_gain());
            if ($urandom_range(0, 3) != 0)
                add_write(REG_GAIN_D, rand_gain());
            if ($urandom_range(0, 3) != 0)
                add_write(REG_INTEGRAL_LIMIT, rand_limit());
            if ($urandom_range(0, 3) != 0)
                add_write(REG_OUTPUT_LIMIT, rand_limit());
            if ($urandom_range(0, 3) == 0)
                add_write(CFG_IDX_W'($urandom_range(int'(REG_OUTPUT_LIMIT) + 1,
                                                    (1 << CFG_IDX_W) - 1)), $urandom());
            target = rand_word();
            plant  = rand_word();
            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                if ($urandom_range(0, 9) < 2)
                    add_sample(rand_word(), rand_word());
                else
                begin
                    if ($urandom_range(0, 31) == 0)
                        target = rand_word();
                    noise = $urandom();
                    noise = noise >>> $urandom_range(10, 30);
                    p = longint'(plant) + ((longint'(target) - longint'(plant)) >>> 3)
                        + longint'(noise);
                    p = sat_word(p);
                    plant = p[Q_W-1:0];
                    add_sample(target, plant);
                end
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (stimulus.size() != 0 || sample_ch.valid || drive_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
